// File: design/tamr_pkg.sv
// Package: shared constants, types and compare functions for tensor_axis_min_reduce.
package tamr_pkg;

	localparam int MaxInner   = 1024;
	localparam int AddrW      = $clog2(MaxInner);
	localparam int ElemW      = 32;
	localparam int CountW     = 16;
	localparam int InnerCntW  = 11;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 16;

	localparam logic [ElemW-1:0] FltMaxBits   = 32'h7F7F_FFFF;
	localparam logic [ElemW-1:0] Int32MaxBits = 32'h7FFF_FFFF;

	localparam logic [CfgIdxW-1:0] RegFormat = 2'd0;
	localparam logic [CfgIdxW-1:0] RegOuter  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegReduce = 2'd2;
	localparam logic [CfgIdxW-1:0] RegInner  = 2'd3;

	typedef logic [ElemW-1:0] elem_t;

	function automatic logic is_nan(input elem_t x);
		is_nan = x[30:0] > 31'h7F80_0000;
	endfunction

	function automatic elem_t order_key(input elem_t x);
		order_key = x[31] ? ~x : {1'b1, x[30:0]};
	endfunction

	// strict a < b in the selected format; in float format NaN and -0 vs +0 never compare less
	function automatic logic elem_less(input logic fmt_int, input elem_t a, input elem_t b);
		logic fl;
		fl = !is_nan(a) && !is_nan(b) && ((a[30:0] | b[30:0]) != 31'd0)
			&& (order_key(a) < order_key(b));
		elem_less = fmt_int ? ($signed(a) < $signed(b)) : fl;
	endfunction

endpackage

// File: design/tamr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tamr_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/tensor_axis_min_reduce.sv
// Top level: streaming min reduction along one tensor axis.
//
//  channel | dir | signals                         | content
//  s_axis  | in  | s_axis_tvalid/tready/tdata[31:0] | element_bits
//  m_axis  | out | m_axis_tvalid/tready/tdata/tlast | min_bits, final_result on tlast
//  cfg     | in  | cfg_we, cfg_idx[1:0], cfg_data   | format, outer, reduce, inner counts
//
// One item per cycle sustained. The accepting edge registers the element and its
// counter position and issues the buffer read; in stage 1 the compare runs and the
// new minimum is written back, and a finished minimum enters the output register as
// stage 1 advances. An element hitting the address written at its accepting edge
// takes the forwarded value. Reset sets float format and counts of one and clears
// counters and valid flags; the minima buffer has no reset, the first reduce slice
// never reads it. Stall: s_axis_tready drops only when the output register holds an
// untaken result and stage 1 also carries one.
module tensor_axis_min_reduce (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,   // [31:0] element_bits
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,   // [31:0] min_bits
	output logic                            m_axis_tlast,   // final_result
	input  logic                            cfg_we,
	input  logic [tamr_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [tamr_pkg::CfgDataW-1:0]   cfg_data
);
	import tamr_pkg::*;

	logic                 fmt_q;
	logic [CountW-1:0]    outer_q, reduce_q;
	logic [InnerCntW-1:0] inner_q;
	logic [AddrW-1:0]     ipos_q;
	logic [CountW-1:0]    rpos_q, opos_q;

	// last indices, zero count acts as one, inner capped
	logic [AddrW-1:0]  last_i, ip;
	logic [CountW-1:0] last_r, last_o, rp, op;
	always_comb begin
		if (inner_q == '0) last_i = '0;
		else if (inner_q > InnerCntW'(MaxInner)) last_i = AddrW'(MaxInner - 1);
		else last_i = AddrW'(inner_q - 1'b1);
		last_r = (reduce_q == '0) ? '0 : reduce_q - 1'b1;
		last_o = (outer_q == '0) ? '0 : outer_q - 1'b1;
		ip = (ipos_q > last_i) ? last_i : ipos_q;
		rp = (rpos_q > last_r) ? last_r : rpos_q;
		op = (opos_q > last_o) ? last_o : opos_q;
	end

	logic v_s1, first_s1, emit_s1, fin_s1;
	logic [AddrW-1:0] addr_s1;
	elem_t elem_s1;

	logic  out_v_q, out_last_q;
	elem_t out_data_q;

	// stage 1 needs room only if it emits; output register frees when taken
	logic out_free, adv;
	assign out_free = !out_v_q || m_axis_tready;
	assign adv = !(v_s1 && emit_s1) || out_free;
	assign s_axis_tready = adv;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	elem_t rdata, cur, newmin;
	tamr_ram #(.Width(ElemW), .Depth(MaxInner)) u_ram (
		.clk(clk), .we(v_s1 && adv), .waddr(addr_s1), .wdata(newmin),
		.re(acc), .raddr(ip), .rdata(rdata)
	);

	// forward the write made at the element's accepting edge to the same address
	logic fwd_s1;
	elem_t fwd_data_s1;
	always_comb begin
		if (first_s1) cur = fmt_q ? Int32MaxBits : FltMaxBits;
		else if (fwd_s1) cur = fwd_data_s1;
		else cur = rdata;
		newmin = elem_less(fmt_q, elem_s1, cur) ? elem_s1 : cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0; outer_q <= 16'd1; reduce_q <= 16'd1; inner_q <= 11'd1;
			ipos_q <= '0; rpos_q <= '0; opos_q <= '0;
			v_s1 <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					RegFormat: fmt_q   <= cfg_data[0];
					RegOuter:  outer_q <= cfg_data;
					RegReduce: reduce_q <= cfg_data;
					RegInner:  inner_q <= cfg_data[InnerCntW-1:0];
					default: ;
				endcase
			end
			if (adv) begin
				v_s1 <= acc;
			end
			if (out_free) begin
				out_v_q <= adv && v_s1 && emit_s1;
			end
			if (acc) begin
				if (ip < last_i) begin
					ipos_q <= ip + 1'b1; rpos_q <= rp; opos_q <= op;
				end else begin
					ipos_q <= '0;
					if (rp < last_r) begin
						rpos_q <= rp + 1'b1; opos_q <= op;
					end else begin
						rpos_q <= '0;
						opos_q <= (op < last_o) ? op + 1'b1 : '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				elem_s1  <= s_axis_tdata;
				addr_s1  <= ip;
				first_s1 <= (rp == '0);
				emit_s1  <= (rp == last_r);
				fin_s1   <= (op == last_o) && (ip == last_i);
				fwd_s1   <= v_s1 && (addr_s1 == ip);
				fwd_data_s1 <= newmin;
			end
		end
		if (out_free && adv && v_s1 && emit_s1) begin
			out_data_q <= newmin;
			out_last_q <= fin_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	// a held result must not be overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result lost");
	// stalled intake only when a result waits
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && v_s1)
		else $error("needless stall");
	// the last flag of a held result stays put
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
		else $error("last flag changed");
`endif
endmodule
